>>> sv/jtpp_pkg.sv
`default_nettype none

package jtpp_pkg;

  // Believed TAP controller state, standard 1149.1 order per bank
  typedef enum logic [4:0] {
    ST_UNKNOWN  = 5'd0,
    ST_RESET    = 5'd1,
    ST_IDLE     = 5'd2,
    ST_SEL_DR   = 5'd3,
    ST_CAP_DR   = 5'd4,
    ST_SHIFT_DR = 5'd5,
    ST_EXIT1_DR = 5'd6,
    ST_PAUSE_DR = 5'd7,
    ST_EXIT2_DR = 5'd8,
    ST_UPD_DR   = 5'd9,
    ST_SEL_IR   = 5'd10,
    ST_CAP_IR   = 5'd11,
    ST_SHIFT_IR = 5'd12,
    ST_EXIT1_IR = 5'd13,
    ST_PAUSE_IR = 5'd14,
    ST_EXIT2_IR = 5'd15,
    ST_UPD_IR   = 5'd16
  } tap_state_e;

  typedef enum logic [1:0] {
    ACT_MOVE      = 2'd0,
    ACT_SHIFT_IR  = 2'd1,
    ACT_SHIFT_DR  = 2'd2,
    ACT_LINK_FAIL = 2'd3
  } action_e;

  // Offsets of the states inside a DR or IR bank
  localparam logic [4:0] OFF_SELECT  = 5'd0;
  localparam logic [4:0] OFF_CAPTURE = 5'd1;
  localparam logic [4:0] OFF_SHIFT   = 5'd2;
  localparam logic [4:0] OFF_EXIT1   = 5'd3;
  localparam logic [4:0] OFF_PAUSE   = 5'd4;
  localparam logic [4:0] OFF_EXIT2   = 5'd5;
  localparam logic [4:0] OFF_UPDATE  = 5'd6;

  // Longest TMS sequence the link takes in one word
  localparam int unsigned TMS_BITS = 16;

  localparam int unsigned RESET_ONES = 5;

  typedef struct packed {
    logic [4:0]  count;
    logic [15:0] bits;
  } path_t;

  typedef path_t [255:0] path_tab_t;

  typedef struct packed {
    logic [2:0] count;
    logic [4:0] pattern;
  } seg_t;

  function automatic logic [4:0] bank_f(input logic [4:0] q);
    bank_f = (q >= ST_SEL_IR) ? ST_SEL_IR : ST_SEL_DR;
  endfunction

  // State that must be reached before q can be entered from c; q if none
  function automatic logic [4:0] pre_f(input logic [4:0] c, input logic [4:0] q);
    logic [4:0] base;
    logic [4:0] k;
    base = bank_f(q);
    k    = q - base;
    if (q == ST_RESET || q == ST_IDLE) begin
      pre_f = q;
    end else begin
      case (k)
        OFF_SELECT: begin
          if (base == ST_SEL_DR) begin
            pre_f = (c != ST_UPD_DR && c != ST_IDLE) ? 5'(ST_IDLE) : q;
          end else begin
            pre_f = (c != ST_UPD_IR) ? 5'(ST_IDLE) : q;
          end
        end
        OFF_CAPTURE: pre_f = base + OFF_SELECT;
        OFF_SHIFT:   pre_f = (c != base + OFF_EXIT2) ? base + OFF_CAPTURE : q;
        OFF_EXIT1:   pre_f = (c != base + OFF_SHIFT) ? base + OFF_CAPTURE : q;
        OFF_PAUSE:   pre_f = base + OFF_EXIT1;
        OFF_EXIT2:   pre_f = base + OFF_PAUSE;
        default: begin
          if (c == base + OFF_EXIT2) begin
            pre_f = q;
          end else if (c == base + OFF_PAUSE) begin
            pre_f = base + OFF_EXIT2;
          end else begin
            pre_f = base + OFF_EXIT1;
          end
        end
      endcase
    end
  endfunction

  // TMS bits that take c straight into q, all prerequisites met
  function automatic seg_t seg_f(input logic [4:0] c, input logic [4:0] q);
    seg_t s;
    logic [4:0] k;
    k = q - bank_f(q);
    if (q == ST_RESET) begin
      s = '{count: 3'd5, pattern: 5'b11111};
    end else if (q == ST_IDLE) begin
      if (c == ST_RESET || c == ST_UPD_DR || c == ST_UPD_IR) begin
        s = '{count: 3'd1, pattern: 5'b00000};
      end else if (c == ST_SEL_IR || c == ST_EXIT1_DR || c == ST_EXIT1_IR ||
                   c == ST_EXIT2_DR || c == ST_EXIT2_IR) begin
        s = '{count: 3'd2, pattern: 5'b00001};
      end else begin
        s = '{count: 3'd3, pattern: 5'b00011};
      end
    end else begin
      case (k)
        OFF_SELECT: begin
          if (q == ST_SEL_DR) s = '{count: 3'd1, pattern: 5'b00001};
          else                s = '{count: 3'd2, pattern: 5'b00011};
        end
        OFF_CAPTURE, OFF_SHIFT, OFF_PAUSE: s = '{count: 3'd1, pattern: 5'b00000};
        default:                           s = '{count: 3'd1, pattern: 5'b00001};
      endcase
    end
    seg_f = s;
  endfunction

  // Full route between two known states, walked hop by hop
  function automatic path_t path_f(input logic [4:0] cur, input logic [4:0] tgt);
    logic [4:0]  c;
    logic [4:0]  q;
    logic [4:0]  p;
    logic [31:0] bits;
    logic [5:0]  len;
    logic        done;
    seg_t        s;
    path_t       r;
    c    = cur;
    bits = '0;
    len  = '0;
    for (int h = 0; h < 16; h++) begin
      if (c != tgt) begin
        q    = tgt;
        done = 1'b0;
        for (int j = 0; j < 16; j++) begin
          if (!done) begin
            p = pre_f(c, q);
            if (p == q || p == c) done = 1'b1;
            else                  q    = p;
          end
        end
        s    = seg_f(c, q);
        bits = bits | (32'(s.pattern) << len);
        len  = len + 6'(s.count);
        c    = q;
      end
    end
    r.bits  = bits[15:0];
    r.count = len[4:0];
    path_f  = r;
  endfunction

  // Index is {cur - 1, tgt - 1} over the known states reset..update-IR
  function automatic path_tab_t build_tab_f();
    path_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = path_f(5'((i >> 4) + 1), 5'((i & 15) + 1));
    end
    build_tab_f = tab;
  endfunction

  localparam path_tab_t PATH_TAB = build_tab_f();

endpackage

`default_nettype wire

>>> sv/jtag_tap_path_planner_top.sv
`default_nettype none

// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: action, target_state; tlast: last_shift
// m_axis    out  m_axis_tvalid/tready      tdata: tms_bits, tms_count, new_state;
//                                          tuser: path_ok
//
// One word in, one word out, one word per cycle sustained while the output is
// not stalled; a word passes the input register, then the result register.
// The route itself is a constant lookup on the registered believed state and
// the target. Reset leaves the believed TAP state unknown and both stages empty.
// A stalled output keeps its word; the input register still takes one more
// word, and the believed state advances only as words move into the result.

module jtag_tap_path_planner_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [1:0] action, [6:2] target_state, [7] zero
  input  wire logic        s_axis_tlast_i,  // last_shift
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [15:0] tms_bits, [20:16] tms_count,
                                            // [25:21] new_state, [31:26] zero
  output logic             m_axis_tuser_o   // path_ok
);

  // Input stage
  logic       in_valid_q, in_valid_d;
  logic [1:0] in_action_q;
  logic [4:0] in_target_q;
  logic       in_last_q;

  // Result stage
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_tdata_q, out_tdata_d;
  logic        out_tuser_q, out_tuser_d;

  // Believed TAP state
  logic [4:0] tap_state_q, tap_state_d;

  logic s_accept;
  logic advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)              out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  // Route planning on the registered word
  logic [4:0]            tgt_eff;
  logic                  is_shift;
  logic                  tgt_known;
  logic                  at_target;
  logic                  from_unknown;
  logic [3:0]            cur_idx;
  logic [3:0]            tgt_idx;
  jtpp_pkg::path_t       entry;
  logic [15:0]           raw_bits;
  logic [5:0]            raw_cnt;
  logic                  fits;
  logic                  ok;
  logic [4:0]            shift_exit1;
  logic [4:0]            state_after;
  logic [4:0]            cur_norm;

  always_comb begin
    is_shift    = 1'b0;
    tgt_eff     = in_target_q;
    shift_exit1 = jtpp_pkg::ST_EXIT1_DR;
    case (in_action_q)
      jtpp_pkg::ACT_SHIFT_IR: begin
        is_shift    = 1'b1;
        tgt_eff     = jtpp_pkg::ST_SHIFT_IR;
        shift_exit1 = jtpp_pkg::ST_EXIT1_IR;
      end
      jtpp_pkg::ACT_SHIFT_DR: begin
        is_shift    = 1'b1;
        tgt_eff     = jtpp_pkg::ST_SHIFT_DR;
      end
      default: ;
    endcase
  end

  // Unknown start: five ones into reset, then the route from reset
  assign from_unknown = (tap_state_q == jtpp_pkg::ST_UNKNOWN);
  assign cur_norm     = from_unknown ? 5'(jtpp_pkg::ST_RESET) : tap_state_q;
  assign cur_idx      = 4'(cur_norm - 5'd1);
  assign tgt_idx      = 4'(tgt_eff - 5'd1);
  assign entry        = jtpp_pkg::PATH_TAB[{cur_idx, tgt_idx}];

  assign tgt_known = (tgt_eff != jtpp_pkg::ST_UNKNOWN) && (tgt_eff <= jtpp_pkg::ST_UPD_IR);
  assign at_target = (tgt_eff == tap_state_q);
  assign raw_bits  = from_unknown ? {entry.bits[10:0], 5'b11111} : entry.bits;
  assign raw_cnt   = 6'(entry.count) + (from_unknown ? 6'(jtpp_pkg::RESET_ONES) : 6'd0);
  assign fits      = (32'(raw_cnt) <= jtpp_pkg::TMS_BITS);
  assign ok        = at_target || (tgt_known && fits);

  always_comb begin
    state_after = ok ? tgt_eff : tap_state_q;
    if (is_shift && in_last_q) state_after = shift_exit1;
  end

  always_comb begin
    tap_state_d = tap_state_q;
    out_tdata_d = out_tdata_q;
    out_tuser_d = out_tuser_q;
    if (advance) begin
      if (in_action_q == jtpp_pkg::ACT_LINK_FAIL) begin
        // Drop belief in the TAP state; report an empty word
        tap_state_d = jtpp_pkg::ST_UNKNOWN;
        out_tdata_d = '0;
        out_tuser_d = 1'b0;
      end else begin
        tap_state_d = state_after;
        out_tuser_d = ok;
        out_tdata_d = '0;
        out_tdata_d[25:21] = state_after;
        if (ok && !at_target) begin
          out_tdata_d[15:0]  = raw_bits;
          out_tdata_d[20:16] = raw_cnt[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tap_state_q <= jtpp_pkg::ST_UNKNOWN;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      tap_state_q <= tap_state_d;
    end
  end

  // Payload: hold unless a word moves in
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_action_q <= s_axis_tdata_i[1:0];
      in_target_q <= s_axis_tdata_i[6:2];
      in_last_q   <= s_axis_tlast_i;
    end
    out_tdata_q <= out_tdata_d;
    out_tuser_q <= out_tuser_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;

endmodule

`default_nettype wire

>>> sv/jtpp_checker.sv
`default_nettype none

module jtpp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  // A failed route sends nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[20:0] == 21'd0))
    else $error("failed route carries TMS bits");

  // No TMS bits above the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[15:0] >> m_axis_tdata_o[20:16]) == 16'd0))
    else $error("TMS bits above count");

  // Count never exceeds the link limit; state stays in the encoding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((32'(m_axis_tdata_o[20:16]) <= jtpp_pkg::TMS_BITS) &&
                         (m_axis_tdata_o[25:21] <= jtpp_pkg::ST_UPD_IR)))
    else $error("count or state out of range");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind jtag_tap_path_planner_top jtpp_checker u_jtpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

>>> verif/tms_path_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels, plans the TMS route for each accepted request
// and compares every result word against the oldest planned one.
module tms_path_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [7:0]  s_data_i,   // [1:0] action, [6:2] target_state, [7] zero
  input  wire logic        s_last_i,   // last_shift
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [31:0] m_data_i,   // [15:0] tms_bits, [20:16] tms_count,
                                       // [25:21] new_state, [31:26] zero
  input  wire logic        m_user_i,   // path_ok
  output int               mismatch_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] tms;
  } hop_t;

  typedef struct packed {
    logic                 ok;
    logic [15:0]          tms;
    logic [4:0]           n_bits;
    jtpp_pkg::tap_state_e state;
  } tms_word_t;

  tms_word_t            planned_words[$];
  tms_word_t            want;
  tms_word_t            got;
  jtpp_pkg::tap_state_e believed;
  jtpp_pkg::action_e    act;
  logic [4:0]           shift_dest;
  int                   errs;

  // State that has to be reached before q can be entered from cur; q if none
  function automatic logic [4:0] needed_first(input logic [4:0] cur, input logic [4:0] q);
    logic [4:0] bank;
    logic [4:0] k;
    bank = (q >= jtpp_pkg::ST_SEL_IR) ? jtpp_pkg::ST_SEL_IR : jtpp_pkg::ST_SEL_DR;
    k    = q - bank;
    if (q == jtpp_pkg::ST_RESET) return q;
    if (cur == jtpp_pkg::ST_UNKNOWN) return jtpp_pkg::ST_RESET;
    if (q == jtpp_pkg::ST_IDLE) return q;
    case (k)
      jtpp_pkg::OFF_SELECT: begin
        if (bank == jtpp_pkg::ST_SEL_DR) begin
          return (cur == jtpp_pkg::ST_UPD_DR || cur == jtpp_pkg::ST_IDLE) ?
                 q : jtpp_pkg::ST_IDLE;
        end
        return (cur == jtpp_pkg::ST_UPD_IR) ? q : jtpp_pkg::ST_IDLE;
      end
      jtpp_pkg::OFF_CAPTURE: return bank + jtpp_pkg::OFF_SELECT;
      jtpp_pkg::OFF_SHIFT:
        return (cur == bank + jtpp_pkg::OFF_EXIT2) ? q : bank + jtpp_pkg::OFF_CAPTURE;
      jtpp_pkg::OFF_EXIT1:
        return (cur == bank + jtpp_pkg::OFF_SHIFT) ? q : bank + jtpp_pkg::OFF_CAPTURE;
      jtpp_pkg::OFF_PAUSE:   return bank + jtpp_pkg::OFF_EXIT1;
      jtpp_pkg::OFF_EXIT2:   return bank + jtpp_pkg::OFF_PAUSE;
      default: begin
        if (cur == bank + jtpp_pkg::OFF_EXIT2) return q;
        if (cur == bank + jtpp_pkg::OFF_PAUSE) return bank + jtpp_pkg::OFF_EXIT2;
        return bank + jtpp_pkg::OFF_EXIT1;
      end
    endcase
  endfunction

  // TMS bits of one hop from cur straight into q
  function automatic hop_t hop_tms(input logic [4:0] cur, input logic [4:0] q);
    logic [4:0] bank;
    logic [4:0] k;
    hop_t       h;
    bank  = (q >= jtpp_pkg::ST_SEL_IR) ? jtpp_pkg::ST_SEL_IR : jtpp_pkg::ST_SEL_DR;
    k     = q - bank;
    h.len = 3'd1;
    h.tms = 5'b00001;
    if (q == jtpp_pkg::ST_RESET) begin
      h.len = 3'd5;
      h.tms = 5'b11111;
    end else if (q == jtpp_pkg::ST_IDLE) begin
      case (cur)
        jtpp_pkg::ST_RESET, jtpp_pkg::ST_UPD_DR, jtpp_pkg::ST_UPD_IR: begin
          h.len = 3'd1;
          h.tms = 5'b00000;
        end
        jtpp_pkg::ST_SEL_IR, jtpp_pkg::ST_EXIT1_DR, jtpp_pkg::ST_EXIT1_IR,
        jtpp_pkg::ST_EXIT2_DR, jtpp_pkg::ST_EXIT2_IR: begin
          h.len = 3'd2;
          h.tms = 5'b00001;
        end
        default: begin
          h.len = 3'd3;
          h.tms = 5'b00011;
        end
      endcase
    end else begin
      case (k)
        jtpp_pkg::OFF_SELECT: begin
          if (bank == jtpp_pkg::ST_SEL_IR) begin
            h.len = 3'd2;
            h.tms = 5'b00011;
          end
        end
        jtpp_pkg::OFF_CAPTURE, jtpp_pkg::OFF_SHIFT, jtpp_pkg::OFF_PAUSE: h.tms = 5'b00000;
        default: h.tms = 5'b00001;
      endcase
    end
    return h;
  endfunction

  // Walk hop by hop from the believed state to tgt; no bits when it fails
  function automatic tms_word_t plan_route(input jtpp_pkg::tap_state_e from,
                                           input logic [4:0] tgt);
    logic [4:0]  cur;
    logic [4:0]  q;
    logic [4:0]  p;
    logic [31:0] acc;
    int unsigned len;
    hop_t        h;
    tms_word_t   w;
    cur = from;
    acc = '0;
    len = 0;
    if (tgt != jtpp_pkg::ST_UNKNOWN && tgt <= jtpp_pkg::ST_UPD_IR) begin
      for (int n = 0; n < 16 && cur != tgt; n++) begin
        q = tgt;
        p = needed_first(cur, q);
        while (p != q && p != cur) begin
          q = p;
          p = needed_first(cur, q);
        end
        h = hop_tms(cur, q);
        if (len < 32) acc = acc | (32'(h.tms) << len);
        len = len + h.len;
        cur = q;
      end
    end
    w.ok     = (cur == tgt) && (len <= jtpp_pkg::TMS_BITS);
    w.tms    = w.ok ? acc[15:0] : 16'h0000;
    w.n_bits = w.ok ? 5'(len) : 5'd0;
    w.state  = from;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      believed = jtpp_pkg::ST_UNKNOWN;
      planned_words.delete();
      errs = 0;
    end else begin
      // Check the result word first: nothing accepted at this edge can be out yet
      if (m_valid_i && m_ready_i) begin
        got.tms    = m_data_i[15:0];
        got.n_bits = m_data_i[20:16];
        got.state  = jtpp_pkg::tap_state_e'(m_data_i[25:21]);
        got.ok     = m_user_i;
        if (planned_words.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected result word: tdata %h tuser %b", m_data_i, m_user_i);
          end
        end else begin
          want = planned_words.pop_front();
          if (got.tms != want.tms || got.n_bits != want.n_bits ||
              got.state != want.state || got.ok != want.ok || m_data_i[31:26] != '0) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: tms exp %h got %h, count exp %0d got %0d,",
                       want.tms, got.tms, want.n_bits, got.n_bits);
              $display("  state exp %0d got %0d, ok exp %0b got %0b, pad %h",
                       want.state, got.state, want.ok, got.ok, m_data_i[31:26]);
            end
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        act = jtpp_pkg::action_e'(s_data_i[1:0]);
        case (act)
          jtpp_pkg::ACT_LINK_FAIL: begin
            believed = jtpp_pkg::ST_UNKNOWN;
            want     = '0;
          end
          jtpp_pkg::ACT_MOVE: begin
            want = plan_route(believed, s_data_i[6:2]);
            if (want.ok) believed = jtpp_pkg::tap_state_e'(s_data_i[6:2]);
          end
          default: begin
            shift_dest = (act == jtpp_pkg::ACT_SHIFT_IR) ? jtpp_pkg::ST_SHIFT_IR :
                                                           jtpp_pkg::ST_SHIFT_DR;
            want = plan_route(believed, shift_dest);
            if (want.ok) believed = jtpp_pkg::tap_state_e'(shift_dest);
            if (s_last_i) begin
              believed = (act == jtpp_pkg::ACT_SHIFT_IR) ? jtpp_pkg::ST_EXIT1_IR :
                                                           jtpp_pkg::ST_EXIT1_DR;
            end
          end
        endcase
        want.state = believed;
        planned_words.push_back(want);
      end
    end
    mismatch_count_o <= errs;
    pending_o        <= planned_words.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the TAP path planner; checking lives in the path
// checker instance next to the block and in the assertions bound into it.
module tb;

  localparam int    WORDS_PER_PHASE = 340;
  localparam int    DRAIN_CYCLES    = 8;
  localparam longint LIMIT_NS       = 5_000_000;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;
  logic        m_user;

  int mismatches;
  int pending;

  // Percent of cycles the sender idles and the receiver stalls
  int idle_pct;
  int stall_pct;

  // Idling plan per phase: none, sender, receiver, both
  int idle_plan[4]  = '{0, 79, 0, 28};
  int stall_plan[4] = '{0, 0, 79, 28};

  jtag_tap_path_planner_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  tms_path_checker path_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_valid_i        (s_valid),
    .s_ready_i        (s_ready),
    .s_data_i         (s_data),
    .s_last_i         (s_last),
    .m_valid_i        (m_valid),
    .m_ready_i        (m_ready),
    .m_data_i         (m_data),
    .m_user_i         (m_user),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a word never arrives
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // Receiver: pick tready afresh at every falling edge
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request word, after a random idle gap, and hold it until taken
  task automatic send_word(input jtpp_pkg::action_e act, input logic [4:0] tgt,
                           input logic end_scan);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, tgt, act};
    s_last  <= end_scan;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  initial begin
    jtpp_pkg::action_e act;
    logic [4:0]        tgt;
    int unsigned       pick;

    rst_n     = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_last    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, back to back
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_IDLE, 1'b0);     // unknown start: five ones first
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_IDLE, 1'b0);     // already there
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UNKNOWN, 1'b0);  // unknown target, known state
    send_word(jtpp_pkg::ACT_MOVE, 5'd17, 1'b0);                 // target just past the range
    send_word(jtpp_pkg::ACT_MOVE, 5'd31, 1'b1);                 // all-ones target
    send_word(jtpp_pkg::ACT_SHIFT_IR, 5'd31, 1'b0);             // into Shift-IR, target ignored
    send_word(jtpp_pkg::ACT_SHIFT_IR, jtpp_pkg::ST_RESET, 1'b1); // end in Exit1-IR
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UPD_IR, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_SEL_IR, 1'b0);   // Select-IR from Update-IR
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UPD_DR, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_SEL_DR, 1'b0);
    send_word(jtpp_pkg::ACT_SHIFT_DR, jtpp_pkg::ST_IDLE, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_EXIT2_DR, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_SHIFT_DR, 1'b0); // Shift-DR from Exit2-DR
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_PAUSE_DR, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UPD_DR, 1'b0);   // from Pause via Exit2
    send_word(jtpp_pkg::ACT_LINK_FAIL, 5'd31, 1'b1);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UNKNOWN, 1'b0);  // unknown target while unknown
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_RESET, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_UPD_IR, 1'b0);
    send_word(jtpp_pkg::ACT_SHIFT_DR, jtpp_pkg::ST_UNKNOWN, 1'b1);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_PAUSE_IR, 1'b0);
    send_word(jtpp_pkg::ACT_MOVE, jtpp_pkg::ST_RESET, 1'b0);
    send_word(jtpp_pkg::ACT_LINK_FAIL, jtpp_pkg::ST_UNKNOWN, 1'b0);
    send_word(jtpp_pkg::ACT_SHIFT_DR, jtpp_pkg::ST_EXIT2_IR, 1'b1); // into Shift-DR from unknown, target ignored

    // Random part: mostly in-range moves and shifts, a few link failures and
    // out-of-range targets to knock the state around
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_plan[ph];
      stall_pct = stall_plan[ph];
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 5)       act = jtpp_pkg::ACT_LINK_FAIL;
        else if (pick < 17) act = jtpp_pkg::ACT_SHIFT_IR;
        else if (pick < 30) act = jtpp_pkg::ACT_SHIFT_DR;
        else                act = jtpp_pkg::ACT_MOVE;
        if ($urandom_range(9) == 0) tgt = 5'($urandom_range(31));
        else                        tgt = 5'($urandom_range(jtpp_pkg::ST_UPD_IR));
        send_word(act, tgt, 1'($urandom_range(1)));
      end
    end

    // Drop valid, drain the pipe, then give a few more cycles for strays
    @(negedge clk);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
